// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file qmof_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/qmof_pkg.sv
// ----------------------------------------------------------------------------
// qmof_pkg
// Types, widths and defaults for the quote mid outlier filter.
// ----------------------------------------------------------------------------
package qmof_pkg;

	localparam int PRICE_W = 48;
	localparam int TIME_W  = 64;
	localparam int WARM_W  = 3;
	localparam int RUN_W   = 4;

	// Reciprocal numerator is 2^32 in Q32.16, so the quotient has 33 bits.
	localparam int RECIP_BITS = 33;
	localparam int ITER_W     = $clog2(RECIP_BITS);

	localparam int WARMUP_QUOTES_DEF  = 4;
	localparam int MAX_REJECT_RUN_DEF = 10;

	typedef logic [PRICE_W-1:0] price_t;
	typedef logic [TIME_W-1:0]  stamp_t;

	typedef struct packed {
		price_t bid_price;
		price_t ask_price;
		price_t quoted_mid;
		stamp_t source_time;
	} quote_t;

	typedef struct packed {
		price_t mid_value;
		stamp_t mid_time;
	} mid_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_TEST
	} state_t;

endpackage

// File: src/qmof_stream_if.sv
// ----------------------------------------------------------------------------
// qmof_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface qmof_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/quote_mid_outlier_filter.sv
// ----------------------------------------------------------------------------
// quote_mid_outlier_filter
// Filters a quote stream into published mid prices with warmup, optional
// reciprocal and a ratio-based outlier reject with a bounded run.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                     | handshake
//  ---------+-----+---------------------------------------------+----------
//  quotes   | in  | bid_price, ask_price, quoted_mid, source_time | valid/ready
//  mids     | out | mid_value, mid_time                         | valid/ready
//  cfg      | in  | cfg_wdata (invert)                          | cfg_we
//
//  A dropped or warmup quote is handled in the idle state. A quote that reaches
//  the test passes the test state, after the divide state if invert is set:
//  the restoring divider produces one quotient bit per cycle and sets the pace.
//  Reset clears the state machine, warmup count, reject run, published value,
//  invert and the output valid. A stalled mids beat holds a quote that passes
//  the test until the output register frees up; quotes are taken only when idle.
// ----------------------------------------------------------------------------
module quote_mid_outlier_filter #(
	parameter int WARMUP_QUOTES  = qmof_pkg::WARMUP_QUOTES_DEF,
	parameter int MAX_REJECT_RUN = qmof_pkg::MAX_REJECT_RUN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	qmof_stream_if.sink          quotes,
	qmof_stream_if.source        mids,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata
);
	import qmof_pkg::*;

	state_t state_q, state_d;

	// Control state
	logic                invert_q;
	logic [WARM_W-1:0]   warm_q;
	logic [RUN_W-1:0]    reject_q;
	price_t              pub_q;
	logic                out_valid_q;
	logic [ITER_W-1:0]   iter_q;

	// Working registers
	price_t              mid_q;     // mid, then quotient accumulator
	price_t              div_q;     // divisor during the reciprocal
	price_t              rem_q;     // partial remainder
	stamp_t              time_q;
	mid_t                out_q;

	// Handshake and decode
	logic                quote_ok;
	logic                in_warmup;
	logic [PRICE_W:0]    pair_sum;
	price_t              mid_in;

	// Divider step
	logic [PRICE_W:0]    rem_shift;
	logic                num_bit;
	logic                q_bit;
	price_t              rem_next;
	logic                div_last;

	// Ratio test
	logic [PRICE_W+3:0]  pub_x10;
	logic [PRICE_W+3:0]  mid_x10;
	logic                outlier;
	logic                do_reject;
	logic                out_free;

	// FSM outputs
	logic                take_warm;
	logic                load_mid;
	logic                div_step;
	logic                reject;
	logic                publish;

	assign quote_ok  = (quotes.data.bid_price != '0) && (quotes.data.ask_price != '0);
	assign in_warmup = warm_q < WARM_W'(WARMUP_QUOTES);

	// Truncating average of bid and ask, unless the feed supplies the mid
	assign pair_sum = {1'b0, quotes.data.bid_price} + {1'b0, quotes.data.ask_price};
	assign mid_in   = (quotes.data.quoted_mid != '0) ? quotes.data.quoted_mid
		: pair_sum[PRICE_W:1];

	// Restoring division of 2^32 by the mid: numerator has a single one at
	// its top bit, which enters on the first iteration.
	assign num_bit   = (iter_q == '0);
	assign rem_shift = {rem_q, num_bit};
	assign q_bit     = rem_shift >= {1'b0, div_q};
	assign rem_next  = q_bit ? PRICE_W'(rem_shift - {1'b0, div_q})
		: rem_shift[PRICE_W-1:0];
	assign div_last  = (iter_q == ITER_W'(RECIP_BITS - 1));

	// Exact ratio test: mid > 10*pub or 10*mid < pub
	assign pub_x10   = {1'b0, pub_q, 3'b000} + {3'b000, pub_q, 1'b0};
	assign mid_x10   = {1'b0, mid_q, 3'b000} + {3'b000, mid_q, 1'b0};
	assign outlier   = (pub_q != '0) &&
		(({4'b0000, mid_q} > pub_x10) || (mid_x10 < {4'b0000, pub_q}));
	assign do_reject = outlier && (reject_q <= RUN_W'(MAX_REJECT_RUN));
	assign out_free  = !out_valid_q || mids.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		quotes.ready = 1'b0;
		take_warm    = 1'b0;
		load_mid     = 1'b0;
		div_step     = 1'b0;
		reject       = 1'b0;
		publish      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// ready is high here, so valid alone marks a beat
				quotes.ready = 1'b1;
				if (quotes.valid && quote_ok) begin
					if (in_warmup) begin
						take_warm = 1'b1;
					end else begin
						load_mid = 1'b1;
						state_d  = invert_q ? ST_DIV : ST_TEST;
					end
				end
			end
			ST_DIV: begin
				div_step = 1'b1;
				if (div_last) begin
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				if (do_reject) begin
					reject  = 1'b1;
					state_d = ST_IDLE;
				end else if (out_free) begin
					publish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q    <= 1'b0;
			warm_q      <= '0;
			reject_q    <= '0;
			pub_q       <= '0;
			out_valid_q <= 1'b0;
			iter_q      <= '0;
		end else begin
			if (cfg_we) begin
				invert_q <= cfg_wdata;
			end
			if (take_warm) begin
				warm_q <= warm_q + WARM_W'(1);
			end
			if (reject) begin
				reject_q <= reject_q + RUN_W'(1);
			end else if (publish) begin
				reject_q <= '0;
				pub_q    <= mid_q;
			end
			// hold the beat until taken, reload on publish
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (mids.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_mid) begin
				iter_q <= '0;
			end else if (div_step) begin
				iter_q <= iter_q + ITER_W'(1);
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (load_mid) begin
			time_q <= quotes.data.source_time;
			div_q  <= mid_in;
			rem_q  <= '0;
			// clear the accumulator when the reciprocal will be shifted in
			mid_q  <= invert_q ? '0 : mid_in;
		end else if (div_step) begin
			rem_q <= rem_next;
			mid_q <= {mid_q[PRICE_W-2:0], q_bit};
		end
		if (publish) begin
			out_q.mid_value <= mid_q;
			out_q.mid_time  <= time_q;
		end
	end

	assign mids.valid = out_valid_q;
	assign mids.data  = out_q;

endmodule

// File: src/qmof_checker.sv
// ----------------------------------------------------------------------------
// qmof_checker
// Port-level checks on the filter's channels, bound into the filter module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qmof_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);
	logic in_beat;

	assign in_beat = in_valid && in_ready;

	// A stalled result beat stays offered
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// A new result never appears right after a quote beat is taken
	`ASSERT_IMPLIES(a_no_fast_out, clk, arst_n, $rose(out_valid), !$past(in_beat))
	// Results are loaded only from the test step, where quotes are refused
	`ASSERT_IMPLIES(a_busy_before_out, clk, arst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind quote_mid_outlier_filter qmof_checker u_qmof_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (quotes.valid),
	.in_ready  (quotes.ready),
	.out_valid (mids.valid),
	.out_ready (mids.ready)
);

// File: verif/quote_mid_checker.sv
// ----------------------------------------------------------------------------
// quote_mid_checker
// Watches the quote, mid and config ports of the outlier filter, predicts
// every published mid and compares each mids beat against the oldest one due.
// ----------------------------------------------------------------------------
module quote_mid_checker #(
	parameter int WARMUP_QUOTES  = qmof_pkg::WARMUP_QUOTES_DEF,
	parameter int MAX_REJECT_RUN = qmof_pkg::MAX_REJECT_RUN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             quote_valid,
	input  logic             quote_ready,
	input  qmof_pkg::quote_t quote,
	input  logic             mid_valid,
	input  logic             mid_ready,
	input  qmof_pkg::mid_t   mid,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	output int               mismatches,
	output int               owed
);
	import qmof_pkg::*;

	localparam logic [63:0] PRICE_TOP = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] RECIP_ONE = 64'h1_0000_0000;

	price_t last_pub;
	int     warm_seen;
	int     reject_len;
	logic   invert_q;
	mid_t   owed_mids[$];

	function automatic void flag(string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t mids: %s", $time, msg);
		end
	endfunction

	// Compute the mid a quote publishes, if any, and queue it.
	task automatic predict_mid(input quote_t q);
		logic [63:0] m;
		mid_t        due;
		if (q.bid_price == '0 || q.ask_price == '0) begin
			return;
		end
		if (warm_seen < WARMUP_QUOTES) begin
			warm_seen++;
			return;
		end
		if (q.quoted_mid != '0) begin
			m = 64'(q.quoted_mid);
		end else begin
			m = (64'(q.bid_price) + 64'(q.ask_price)) >> 1;
		end
		if (invert_q) begin
			m = RECIP_ONE / m;
			if (m > PRICE_TOP) begin
				m = PRICE_TOP;
			end
		end
		if (last_pub != '0 && reject_len <= MAX_REJECT_RUN &&
				(m > 64'(last_pub) * 10 || m * 10 < 64'(last_pub))) begin
			reject_len++;
			return;
		end
		reject_len    = 0;
		last_pub      = price_t'(m);
		due.mid_value = last_pub;
		due.mid_time  = q.source_time;
		owed_mids     = {owed_mids, due};
	endtask

	task automatic check_mid(input mid_t got);
		mid_t due;
		if (owed_mids.size() == 0) begin
			flag($sformatf("unexpected beat value %h time %h", got.mid_value, got.mid_time));
			return;
		end
		due = owed_mids.pop_front();
		if (got.mid_value !== due.mid_value) begin
			flag($sformatf("mid_value expected %h got %h", due.mid_value, got.mid_value));
		end
		if (got.mid_time !== due.mid_time) begin
			flag($sformatf("mid_time expected %h got %h", due.mid_time, got.mid_time));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pub   = '0;
			warm_seen  = 0;
			reject_len = 0;
			invert_q   = 1'b0;
			mismatches = 0;
			owed_mids.delete();
		end else begin
			if (cfg_we) begin
				invert_q = cfg_wdata;
			end
			if (mid_valid && mid_ready) begin
				check_mid(mid);
			end
			if (quote_valid && quote_ready) begin
				predict_mid(quote);
			end
		end
		owed = owed_mids.size();
	end

endmodule

// File: verif/tb_quote_mid_outlier_filter.sv
// ----------------------------------------------------------------------------
// tb_quote_mid_outlier_filter
// Drives quotes into the outlier filter and drains its mids with random gaps
// and stalls; a checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_quote_mid_outlier_filter;
	import qmof_pkg::*;

	localparam int     WARMUP        = WARMUP_QUOTES_DEF;
	localparam int     MAX_RUN       = MAX_REJECT_RUN_DEF;
	localparam int     DRAIN_CYCLES  = 40;      // lets an inverted quote finish its divide and test steps
	localparam int     LONG_HOLD     = 300;
	localparam int     RANDOM_PHASES = 6;
	localparam int     PHASE_ITEMS   = 100;
	localparam price_t PRICE_MAX     = '1;
	localparam price_t RECIP_UNIT    = 48'h1_0000_0000;  // 2^32, inverts to 1

	logic   clk;
	logic   arst_n;
	logic   cfg_we;
	logic   cfg_wdata;
	int     mismatches;
	int     owed;
	bit     calm;        // when set, neither side idles
	bit     hold_req;    // ask the mids side for one long hold-off
	price_t level;       // price around which well-formed quotes sit
	int     burst_left;  // outliers still to send in the current burst

	qmof_stream_if #(.payload_t(quote_t)) quotes_if ();
	qmof_stream_if #(.payload_t(mid_t))   mids_if ();

	quote_mid_outlier_filter #(
		.WARMUP_QUOTES  (WARMUP),
		.MAX_REJECT_RUN (MAX_RUN)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.quotes    (quotes_if),
		.mids      (mids_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	quote_mid_checker #(
		.WARMUP_QUOTES  (WARMUP),
		.MAX_REJECT_RUN (MAX_RUN)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.quote_valid (quotes_if.valid),
		.quote_ready (quotes_if.ready),
		.quote       (quotes_if.data),
		.mid_valid   (mids_if.valid),
		.mid_ready   (mids_if.ready),
		.mid         (mids_if.data),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.owed        (owed)
	);

	// 2-unit clock period
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Kill a hung run; the slowest legal run is far below this.
	initial begin
		#400000;
		$display("tb_quote_mid_outlier_filter NOT OK");
		$finish;
	end

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	// Nonzero price of random bit length, up to max_w bits.
	function automatic price_t rand_width_price(input int max_w);
		int     w;
		price_t p;
		w = $urandom_range(1, max_w);
		p = price_t'(rnd64()) & ((48'd1 << w) - 48'd1);
		if (p == '0) begin
			p = 48'd1;
		end
		return p;
	endfunction

	function automatic quote_t quote_of(input price_t bid, input price_t ask,
			input price_t qmid, input stamp_t t);
		quote_t q;
		q.bid_price   = bid;
		q.ask_price   = ask;
		q.quoted_mid  = qmid;
		q.source_time = t;
		return q;
	endfunction

	// Build one random quote. Most quotes sit close to the current level so
	// that the ratio test passes; the rest are missing sides, full-range
	// noise, level jumps (which start reject runs) and outlier bursts long
	// enough to exhaust the reject run and force an acceptance.
	function automatic quote_t make_quote();
		quote_t      q;
		logic [63:0] span;
		logic [63:0] m;
		int          pick;
		pick = $urandom_range(0, 99);
		if (burst_left > 0) begin
			burst_left--;
			pick = 99;
		end else if (pick >= 16 && pick < 19) begin
			burst_left = MAX_RUN + 1;
			pick = 99;
		end
		if (pick >= 12 && pick < 16) begin
			level = rand_width_price(47);
		end
		span          = 64'(level) / 32 + 1;
		q.source_time = rnd64();
		q.bid_price   = price_t'(64'(level) - rnd64() % span);
		q.ask_price   = price_t'(64'(level) + rnd64() % span);
		q.quoted_mid  = $urandom_range(0, 1) ? '0 : price_t'(64'(level) + rnd64() % span);
		if (pick < 8) begin
			// drop one or both sides
			q.quoted_mid = price_t'(rnd64());
			case ($urandom_range(0, 2))
				0: begin
					q.bid_price = '0;
					q.ask_price = price_t'(rnd64());
				end
				1: begin
					q.bid_price = price_t'(rnd64());
					q.ask_price = '0;
				end
				default: begin
					q.bid_price = '0;
					q.ask_price = '0;
				end
			endcase
		end else if (pick < 12) begin
			q.bid_price  = price_t'(rnd64());
			q.ask_price  = price_t'(rnd64());
			q.quoted_mid = $urandom_range(0, 1) ? '0 : price_t'(rnd64());
		end else if (pick >= 90) begin
			case ($urandom_range(0, 4))
				0: begin
					m = 64'(level) * 11 + rnd64() % span;
					if (m > 64'(PRICE_MAX)) begin
						m = 64'(PRICE_MAX);
					end
				end
				1: m = 64'(level) / 11;
				2: m = 64'd1;
				3: m = 64'(PRICE_MAX);
				default: m = 64'(RECIP_UNIT);
			endcase
			if (m == 0) begin
				m = 64'd1;
			end
			q.quoted_mid = price_t'(m);
		end
		return q;
	endfunction

	// Offer one quote beat. Enter and leave at a falling edge; valid stays
	// high on exit so a back-to-back beat needs no drop.
	task automatic offer_quote(input quote_t q);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			quotes_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		quotes_if.valid <= 1'b1;
		quotes_if.data  <= q;
		do @(posedge clk); while (!(quotes_if.valid && quotes_if.ready));
		@(negedge clk);
	endtask

	// Write the invert bit once the filter has drained. A rejected or warmup
	// quote leaves nothing owed, so wait out the divider as well.
	task automatic write_invert(input logic v);
		quotes_if.valid <= 1'b0;
		while (owed != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mids side: draw a stall per beat, honor one long hold-off on request
	// so the output register fills and the quote side backs up.
	initial begin
		int stall;
		mids_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = calm ? 0 : $urandom_range(0, 8);
			if (hold_req) begin
				stall    = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (stall > 0) begin
				mids_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			mids_if.ready <= 1'b1;
			do @(posedge clk); while (!(mids_if.valid && mids_if.ready));
		end
	end

	// Stimulus and verdict
	initial begin
		int counted;
		quote_t q;
		quotes_if.valid = 1'b0;
		quotes_if.data  = '0;
		cfg_we          = 1'b0;
		cfg_wdata       = 1'b0;
		calm            = 1'b0;
		hold_req        = 1'b0;
		burst_left      = 0;
		level           = 48'd100 << 16;
		arst_n          = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_invert(1'b0);

		// Missing sides: dropped without touching warmup.
		offer_quote(quote_of('0, PRICE_MAX, PRICE_MAX, '1));
		offer_quote(quote_of(PRICE_MAX, '0, '0, '0));
		offer_quote(quote_of('0, '0, 48'd1, rnd64()));
		// Warmup quotes, all discarded.
		repeat (WARMUP) begin
			offer_quote(quote_of(rand_width_price(48), rand_width_price(48), '0, rnd64()));
		end
		// Full-scale average with no published value yet.
		offer_quote(quote_of(PRICE_MAX, PRICE_MAX, '0, '1));
		// Truncated average of 1 and 2 is an outlier: the first eleven are
		// rejected, the twelfth goes through once the run is spent.
		repeat (MAX_RUN + 2) begin
			offer_quote(quote_of(48'd1, 48'd2, '0, rnd64()));
		end
		// Ratio edges around a published value of 10 LSB.
		offer_quote(quote_of(48'd10, 48'd10, '0, rnd64()));
		offer_quote(quote_of(48'd101, 48'd101, '0, rnd64()));
		offer_quote(quote_of(48'd1, 48'd1, '0, rnd64()));

		// Reciprocal: 2^32 maps to 1, one LSB maps to 2^32, full scale to 0.
		write_invert(1'b1);
		offer_quote(quote_of(48'd1, 48'd1, RECIP_UNIT, rnd64()));
		offer_quote(quote_of(48'd1, 48'd1, 48'd1, rnd64()));
		offer_quote(quote_of(PRICE_MAX, PRICE_MAX, '0, rnd64()));

		// Random phases, alternating invert; only quotes with both sides
		// present advance the count.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_invert(ph[0]);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				if ($urandom_range(0, 24) == 0) begin
					calm = ($urandom_range(0, 2) == 0);
				end
				if (ph == 0 && counted == 30 && !hold_req) begin
					calm     = 1'b1;
					hold_req = 1'b1;
				end
				q = make_quote();
				if (q.bid_price != '0 && q.ask_price != '0) begin
					counted++;
				end
				offer_quote(q);
			end
		end

		// Drain: park the sender, wait for every owed mid, then linger.
		quotes_if.valid <= 1'b0;
		while (owed != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && owed == 0) begin
			$display("tb_quote_mid_outlier_filter OK");
		end else begin
			$display("tb_quote_mid_outlier_filter NOT OK");
		end
		$finish;
	end

endmodule
